@@ rtl/rgb_hsl_converter_top_macros.svh @@
// ----------------------------------------------------------------------------
// rgb_hsl_converter_top_macros.svh
// Assertion macros shared by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef RGB_HSL_CONVERTER_TOP_MACROS_SVH
`define RGB_HSL_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg
// Constants and types for the RGB/HSL converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int unsigned HUE_SECTOR = 3840;     // 60 degrees, 6 fraction bits
   localparam int unsigned HUE_FULL   = 23040;    // 360 degrees
   localparam int unsigned Q_ONE      = 4096;     // 1.0 in Q0.12
   localparam int unsigned L_RECIP    = 1052689;  // ceil(2^28 / 255)
   localparam int unsigned L_SHIFT    = 28;

   localparam int unsigned HUE_W  = 15;
   localparam int unsigned SL_W   = 13;
   localparam int unsigned COMP_W = 8;

   localparam int unsigned DIV_STAGES = 4;

   typedef enum logic {
      OP_RGB2HSL = 1'b0,
      OP_HSL2RGB = 1'b1
   } rhc_op_type;

   // colour as given (HSL already wrapped / saturated)
   typedef struct packed {
      rhc_op_type          op;
      logic [COMP_W-1:0]   red;
      logic [COMP_W-1:0]   green;
      logic [COMP_W-1:0]   blue;
      logic [HUE_W-1:0]    hue;
      logic [SL_W-1:0]     sat;
      logic [SL_W-1:0]     light;
   } rhc_echo_type;

endpackage

@@ rtl/rhc_divider.sv @@
// ----------------------------------------------------------------------------
// rhc_divider
// Pipelined restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module rhc_divider
   import rhc_pkg::*;
#(
   parameter int unsigned QW     = HUE_W,
   parameter int unsigned DW     = COMP_W,
   parameter int unsigned STAGES = DIV_STAGES
) (
   input  logic             clock,
   input  logic             en,
   input  logic [QW+DW-1:0] num_in,   // must be below den * 2^QW
   input  logic [DW-1:0]    den_in,   // nonzero
   output logic [QW-1:0]    quot_out
);

   localparam int unsigned BPS = (QW + STAGES - 1) / STAGES;
   localparam int unsigned RW  = QW + DW;

   logic [RW-1:0] rem_ff  [STAGES];
   logic [QW-1:0] quot_ff [STAGES];
   logic [DW-1:0] den_ff  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quot_in;
      logic [RW-1:0] prev_rem;
      logic [QW-1:0] prev_quot;
      logic [DW-1:0] prev_den;

      if (s == 0) begin : g_first
         assign prev_rem  = num_in;
         assign prev_quot = '0;
         assign prev_den  = den_in;
      end else begin : g_next
         assign prev_rem  = rem_ff[s-1];
         assign prev_quot = quot_ff[s-1];
         assign prev_den  = den_ff[s-1];
      end

      always_comb begin
         logic [RW-1:0] trial;
         int            idx;
         rem_in  = prev_rem;
         quot_in = prev_quot;
         for (int j = 0; j < BPS; j++) begin
            idx   = QW - 1 - (s * BPS + j);
            trial = '0;
            if (idx >= 0) begin
               trial = RW'(prev_den) << idx;
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  quot_in = quot_in | (QW'(1) << idx);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            quot_ff[s] <= quot_in;
            den_ff[s]  <= prev_den;
         end
      end
   end

   assign quot_out = quot_ff[STAGES-1];

endmodule

@@ rtl/rgb_hsl_converter_top.sv @@
// ----------------------------------------------------------------------------
// rgb_hsl_converter_top
// RGB <-> fixed-point HSL converter, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while the output is not stalled and returns
// one result per item. The depth is set by the two hue/saturation dividers
// (four stages, four quotient bits each) plus a preparation stage and the
// output register; the HSL to RGB path runs in parallel over the same
// stages. Hue is degrees x 64 (0..23039), S and L are Q0.12 (4096 = 1.0).
// Hue at or above 360 degrees is wrapped, S and L above 1.0 are saturated,
// and the adjusted HSL is echoed. A stall while a result is valid freezes
// the whole pipe and back-pressures the request side in the same cycle.
// ----------------------------------------------------------------------------
module rgb_hsl_converter_top
   import rhc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [COMP_W-1:0] req_in_red,
   input  logic [COMP_W-1:0] req_in_green,
   input  logic [COMP_W-1:0] req_in_blue,
   input  logic [HUE_W-1:0]  req_in_hue,
   input  logic [SL_W-1:0]   req_in_saturation,
   input  logic [SL_W-1:0]   req_in_lightness,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [COMP_W-1:0] rsp_out_red,
   output logic [COMP_W-1:0] rsp_out_green,
   output logic [COMP_W-1:0] rsp_out_blue,
   output logic [HUE_W-1:0]  rsp_out_hue,
   output logic [SL_W-1:0]   rsp_out_saturation,
   output logic [SL_W-1:0]   rsp_out_lightness
);

   localparam int unsigned HNUM_W = HUE_W + COMP_W;   // hue numerator
   localparam int unsigned SNUM_W = SL_W + COMP_W;    // saturation numerator
   localparam int unsigned ACC_W  = 38;               // RGB accumulator, 3840*2^25 max
   localparam int unsigned CQ_W   = 25;               // chroma, up to 2^24

   // Pipe advances unless a finished result is being held.
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ------------------------------------------------------------------------
   // Stage 1: wrap/saturate, max/min, divider operands, sector split
   // ------------------------------------------------------------------------
   logic [HUE_W-1:0]  hw;
   logic [SL_W-1:0]   sc, lc;
   logic [2:0]        k_in;
   logic [11:0]       f_in, fx_in;
   logic [SL_W-1:0]   dist_in;
   logic [SL_W:0]     twol;
   logic [COMP_W-1:0] mx, mn, dlt;
   logic [8:0]        sum;
   logic [11:0]       ht;
   logic [HNUM_W-1:0] hnum_in;
   logic [COMP_W-1:0] hden_in, sden_in;
   logic [SNUM_W-1:0] snum_in;
   logic [8:0]        sdist;
   rhc_echo_type      echo_in;

   always_comb begin
      hw = (req_in_hue >= HUE_W'(HUE_FULL)) ? req_in_hue - HUE_W'(HUE_FULL) : req_in_hue;
      sc = (req_in_saturation > SL_W'(Q_ONE)) ? SL_W'(Q_ONE) : req_in_saturation;
      lc = (req_in_lightness > SL_W'(Q_ONE)) ? SL_W'(Q_ONE) : req_in_lightness;

      priority if (hw >= HUE_W'(5 * HUE_SECTOR)) k_in = 3'd5;
      else if (hw >= HUE_W'(4 * HUE_SECTOR))     k_in = 3'd4;
      else if (hw >= HUE_W'(3 * HUE_SECTOR))     k_in = 3'd3;
      else if (hw >= HUE_W'(2 * HUE_SECTOR))     k_in = 3'd2;
      else if (hw >= HUE_W'(HUE_SECTOR))         k_in = 3'd1;
      else                                       k_in = 3'd0;
      f_in  = 12'(hw - HUE_W'(k_in) * HUE_W'(HUE_SECTOR));
      fx_in = k_in[0] ? 12'(HUE_SECTOR) - f_in : f_in;

      twol    = {lc, 1'b0};
      dist_in = (twol >= (SL_W+1)'(Q_ONE)) ? SL_W'(twol - (SL_W+1)'(Q_ONE))
                                           : SL_W'((SL_W+1)'(Q_ONE) - twol);

      // RGB side
      mx  = (req_in_red > req_in_green) ? req_in_red : req_in_green;
      mx  = (mx > req_in_blue) ? mx : req_in_blue;
      mn  = (req_in_red < req_in_green) ? req_in_red : req_in_green;
      mn  = (mn < req_in_blue) ? mn : req_in_blue;
      dlt = mx - mn;
      sum = 9'(mx) + 9'(mn);

      // hue numerator over 3840; arithmetic is modulo 2^12, true value >= 0
      priority if (dlt == '0) ht = '0;
      else if (mx == req_in_red) begin
         if (req_in_green >= req_in_blue)
            ht = 12'(req_in_green) - 12'(req_in_blue);
         else
            ht = 12'(dlt) * 12'd6 - (12'(req_in_blue) - 12'(req_in_green));
      end else if (mx == req_in_green)
         ht = 12'(dlt) * 12'd2 + 12'(req_in_blue) - 12'(req_in_red);
      else
         ht = 12'(dlt) * 12'd4 + 12'(req_in_red) - 12'(req_in_green);
      hnum_in = HNUM_W'(24'(ht) * 24'(HUE_SECTOR));
      hden_in = (dlt == '0) ? COMP_W'(1) : dlt;

      // saturation: zero at black and white
      sdist = (sum >= 9'd255) ? sum - 9'd255 : 9'd255 - sum;
      if (sum == '0 || sum >= 9'd510) begin
         snum_in = '0;
         sden_in = COMP_W'(1);
      end else begin
         snum_in = SNUM_W'({dlt, 12'b0});
         sden_in = COMP_W'(9'd255 - sdist);
      end

      echo_in.op    = rhc_op_type'(req_opcode);
      echo_in.red   = req_in_red;
      echo_in.green = req_in_green;
      echo_in.blue  = req_in_blue;
      echo_in.hue   = hw;
      echo_in.sat   = sc;
      echo_in.light = lc;
   end

   logic              s1_valid_ff;
   rhc_echo_type      s1_echo_ff;
   logic [2:0]        s1_k_ff;
   logic [11:0]       s1_fx_ff;
   logic [SL_W-1:0]   s1_dist_ff;
   logic [8:0]        s1_sum_ff;
   logic [HNUM_W-1:0] s1_hnum_ff;
   logic [COMP_W-1:0] s1_hden_ff, s1_sden_ff;
   logic [SNUM_W-1:0] s1_snum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_echo_ff <= echo_in;
         s1_k_ff    <= k_in;
         s1_fx_ff   <= fx_in;
         s1_dist_ff <= dist_in;
         s1_sum_ff  <= sum;
         s1_hnum_ff <= hnum_in;
         s1_hden_ff <= hden_in;
         s1_snum_ff <= snum_in;
         s1_sden_ff <= sden_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stages 2..5: dividers for hue and saturation
   // ------------------------------------------------------------------------
   logic [HUE_W-1:0] hue_q;
   logic [SL_W-1:0]  sat_q;

   rhc_divider #(
      .QW     (HUE_W),
      .DW     (COMP_W),
      .STAGES (DIV_STAGES)
   ) u_hue_div (
      .clock    (clock),
      .en       (en),
      .num_in   (s1_hnum_ff),
      .den_in   (s1_hden_ff),
      .quot_out (hue_q)
   );

   rhc_divider #(
      .QW     (SL_W),
      .DW     (COMP_W),
      .STAGES (DIV_STAGES)
   ) u_sat_div (
      .clock    (clock),
      .en       (en),
      .num_in   (s1_snum_ff),
      .den_in   (s1_sden_ff),
      .quot_out (sat_q)
   );

   // ------------------------------------------------------------------------
   // Stage 2: chroma product, lightness = floor(sum * 2048 / 255)
   // ------------------------------------------------------------------------
   logic [CQ_W-1:0] cq_in;
   logic [40:0]     lprod;

   assign cq_in = CQ_W'((26'(Q_ONE) - 26'(s1_dist_ff)) * 26'(s1_echo_ff.sat));
   assign lprod = {s1_sum_ff, 11'b0, 21'b0} == '0 ? '0
                : 41'({s1_sum_ff, 11'b0}) * 41'(L_RECIP);

   logic            s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   rhc_echo_type    s2_echo_ff, s3_echo_ff, s4_echo_ff, s5_echo_ff;
   logic [SL_W-1:0] s2_light_ff, s3_light_ff, s4_light_ff, s5_light_ff;
   logic [2:0]      s2_k_ff, s3_k_ff;
   logic [11:0]     s2_fx_ff;
   logic [CQ_W-1:0] s2_cq_ff;

   // ------------------------------------------------------------------------
   // Stage 3: x term, chroma term and base offset, all over 3840 * 2^25
   // ------------------------------------------------------------------------
   logic [ACC_W-1:0] xn_in, cn_in, base_in;

   always_comb begin
      xn_in   = ACC_W'(ACC_W'(s2_cq_ff) * ACC_W'(s2_fx_ff)) << 1;
      cn_in   = ACC_W'(s2_cq_ff) * ACC_W'(2 * HUE_SECTOR);
      base_in = ACC_W'(((ACC_W'(s2_echo_ff.light) << 13) - ACC_W'(s2_cq_ff))
                       * ACC_W'(HUE_SECTOR));
   end

   logic [ACC_W-1:0] s3_xn_ff, s3_cn_ff, s3_base_ff;

   // ------------------------------------------------------------------------
   // Stage 4: sector select and scale: floor(A*255/(15*2^33)) = (A*17) >> 33
   // ------------------------------------------------------------------------
   function automatic logic [COMP_W-1:0] scale_comp(input logic [ACC_W-1:0] base,
                                                    input logic [ACC_W-1:0] term);
      logic [ACC_W-1:0] a;
      logic [ACC_W+4:0] p;
      logic [ACC_W-29:0] v;
      a = base + term;
      p = ((ACC_W+5)'(a) << 4) + (ACC_W+5)'(a);
      v = p[ACC_W+4:33];
      return (v > (ACC_W-28)'(255)) ? COMP_W'(255) : COMP_W'(v);
   endfunction

   logic [ACC_W-1:0]  tr, tg, tb;
   logic [COMP_W-1:0] r_in, g_in, b_in;

   always_comb begin
      tr = '0;
      tg = '0;
      tb = '0;
      unique case (s3_k_ff)
         3'd0:    begin tr = s3_cn_ff; tg = s3_xn_ff; end
         3'd1:    begin tr = s3_xn_ff; tg = s3_cn_ff; end
         3'd2:    begin tg = s3_cn_ff; tb = s3_xn_ff; end
         3'd3:    begin tg = s3_xn_ff; tb = s3_cn_ff; end
         3'd4:    begin tr = s3_xn_ff; tb = s3_cn_ff; end
         default: begin tr = s3_cn_ff; tb = s3_xn_ff; end
      endcase
      r_in = scale_comp(s3_base_ff, tr);
      g_in = scale_comp(s3_base_ff, tg);
      b_in = scale_comp(s3_base_ff, tb);
   end

   logic [COMP_W-1:0] s4_r_ff, s4_g_ff, s4_b_ff, s5_r_ff, s5_g_ff, s5_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_echo_ff  <= s1_echo_ff;
         s2_light_ff <= lprod[40:L_SHIFT];
         s2_k_ff     <= s1_k_ff;
         s2_fx_ff    <= s1_fx_ff;
         s2_cq_ff    <= cq_in;

         s3_echo_ff  <= s2_echo_ff;
         s3_light_ff <= s2_light_ff;
         s3_k_ff     <= s2_k_ff;
         s3_xn_ff    <= xn_in;
         s3_cn_ff    <= cn_in;
         s3_base_ff  <= base_in;

         s4_echo_ff  <= s3_echo_ff;
         s4_light_ff <= s3_light_ff;
         s4_r_ff     <= r_in;
         s4_g_ff     <= g_in;
         s4_b_ff     <= b_in;

         s5_echo_ff  <= s4_echo_ff;
         s5_light_ff <= s4_light_ff;
         s5_r_ff     <= s4_r_ff;
         s5_g_ff     <= s4_g_ff;
         s5_b_ff     <= s4_b_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: output register, picks given vs converted per opcode
   // ------------------------------------------------------------------------
   logic              rsp_valid_ff;
   logic [COMP_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [HUE_W-1:0]  rsp_hue_ff;
   logic [SL_W-1:0]   rsp_sat_ff, rsp_light_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (s5_echo_ff.op == OP_RGB2HSL) begin
            rsp_red_ff   <= s5_echo_ff.red;
            rsp_green_ff <= s5_echo_ff.green;
            rsp_blue_ff  <= s5_echo_ff.blue;
            rsp_hue_ff   <= hue_q;
            rsp_sat_ff   <= sat_q;
            rsp_light_ff <= s5_light_ff;
         end else begin
            rsp_red_ff   <= s5_r_ff;
            rsp_green_ff <= s5_g_ff;
            rsp_blue_ff  <= s5_b_ff;
            rsp_hue_ff   <= s5_echo_ff.hue;
            rsp_sat_ff   <= s5_echo_ff.sat;
            rsp_light_ff <= s5_echo_ff.light;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_red        = rsp_red_ff;
   assign rsp_out_green      = rsp_green_ff;
   assign rsp_out_blue       = rsp_blue_ff;
   assign rsp_out_hue        = rsp_hue_ff;
   assign rsp_out_saturation = rsp_sat_ff;
   assign rsp_out_lightness  = rsp_light_ff;

endmodule

@@ rtl/rhc_checker.sv @@
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level assertions for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_hsl_converter_top_macros.svh"

module rhc_checker
   import rhc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_opcode,
   input logic [COMP_W-1:0] req_in_red,
   input logic [COMP_W-1:0] req_in_green,
   input logic [COMP_W-1:0] req_in_blue,
   input logic [HUE_W-1:0]  req_in_hue,
   input logic [SL_W-1:0]   req_in_saturation,
   input logic [SL_W-1:0]   req_in_lightness,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [COMP_W-1:0] rsp_out_red,
   input logic [COMP_W-1:0] rsp_out_green,
   input logic [COMP_W-1:0] rsp_out_blue,
   input logic [HUE_W-1:0]  rsp_out_hue,
   input logic [SL_W-1:0]   rsp_out_saturation,
   input logic [SL_W-1:0]   rsp_out_lightness
);

   // held result stays up
   `RHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   // held result's hue, red and lightness do not change
   `RHC_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_out_hue) && $stable(rsp_out_red) && $stable(rsp_out_lightness), "rsp payload moved while stalled")

   // input back-pressure only comes from a held result
   `RHC_ASSERT_NOW(a_req_stall_cause, req_stall, rsp_valid && rsp_stall, "req stalled without output stall")

   // hue, saturation and lightness always in range for either conversion
   `RHC_ASSERT_NOW(a_rsp_range, rsp_valid, (rsp_out_hue < HUE_W'(HUE_FULL)) && (rsp_out_saturation <= SL_W'(Q_ONE)) && (rsp_out_lightness <= SL_W'(Q_ONE)), "rsp field out of range")

endmodule

bind rgb_hsl_converter_top rhc_checker u_rhc_checker (.*);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_hsl_converter_top: directed corner colours,
// then random RGB and HSL transfers under several idle/stall mixes, each
// result compared field by field with an exact integer color predictor.
// ----------------------------------------------------------------------------
module tb;
   import rhc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES   = 20;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic [HUE_W-1:0]  hue;
      logic [SL_W-1:0]   sat;
      logic [SL_W-1:0]   light;
   } color_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_opcode;
   logic [COMP_W-1:0] req_in_red, req_in_green, req_in_blue;
   logic [HUE_W-1:0]  req_in_hue;
   logic [SL_W-1:0]   req_in_saturation, req_in_lightness;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [COMP_W-1:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [HUE_W-1:0]  rsp_out_hue;
   logic [SL_W-1:0]   rsp_out_saturation, rsp_out_lightness;

   color_type expected_colors[$];
   int        mismatch_count;
   int        send_idle_pct;   // chance in percent of an idle cycle before a transfer
   int        stall_pct;       // chance in percent of the receiver stalling
   int        hold_off_cycles; // long receiver hold-off, counted by the stall process
   int        quiet_cycles;

   rgb_hsl_converter_top DUT (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------------
   // Predictor: exact integer color conversion, floor of each result
   // ---------------------------------------------------------------------
   function automatic color_type convert_color(rhc_op_type op, color_type given);
      color_type  res;
      longint unsigned r, g, b, mx, mn, d, sum, num, spread, den;
      longint unsigned h, s, l, cq, k, f, fx, cn, xn, mterm, tr, tg, tb, v;
      res = given;
      if (op == OP_RGB2HSL) begin
         r = given.red; g = given.green; b = given.blue;
         mx = (r > g) ? r : g; mx = (mx > b) ? mx : b;
         mn = (r < g) ? r : g; mn = (mn < b) ? mn : b;
         d = mx - mn;
         sum = mx + mn;
         if (d == 0) begin
            h = 0;
         end else if (mx == r) begin
            // negative hue wraps by a full turn
            num = (g >= b) ? HUE_SECTOR * (g - b) : HUE_FULL * d - HUE_SECTOR * (b - g);
            h = num / d;
         end else if (mx == g) begin
            h = (2 * HUE_SECTOR * d + HUE_SECTOR * b - HUE_SECTOR * r) / d;
         end else begin
            h = (4 * HUE_SECTOR * d + HUE_SECTOR * r - HUE_SECTOR * g) / d;
         end
         l = (sum * Q_ONE) / 510;
         if (sum == 0 || sum >= 510) begin
            s = 0;
         end else begin
            spread = (sum >= 255) ? sum - 255 : 255 - sum;
            s = (d * Q_ONE) / (255 - spread);
         end
         res.hue = HUE_W'(h); res.sat = SL_W'(s); res.light = SL_W'(l);
      end else begin
         h = given.hue; s = given.sat; l = given.light;
         if (h >= HUE_FULL) h = h - HUE_FULL;
         if (s > Q_ONE) s = Q_ONE;
         if (l > Q_ONE) l = Q_ONE;
         den = longint'(HUE_SECTOR) << 25;
         spread = (2 * l >= Q_ONE) ? 2 * l - Q_ONE : Q_ONE - 2 * l;
         cq = (Q_ONE - spread) * s;
         k = h / HUE_SECTOR;
         f = h % HUE_SECTOR;
         fx = k[0] ? HUE_SECTOR - f : f;
         cn = cq * HUE_SECTOR * 2;
         xn = cq * fx * 2;
         mterm = l * HUE_SECTOR * 8192 - cq * HUE_SECTOR;
         tr = 0; tg = 0; tb = 0;
         case (k)
            0: begin tr = cn; tg = xn; end
            1: begin tr = xn; tg = cn; end
            2: begin tg = cn; tb = xn; end
            3: begin tg = xn; tb = cn; end
            4: begin tr = xn; tb = cn; end
            default: begin tr = cn; tb = xn; end
         endcase
         v = ((tr + mterm) * 255) / den; res.red   = COMP_W'((v > 255) ? 255 : v);
         v = ((tg + mterm) * 255) / den; res.green = COMP_W'((v > 255) ? 255 : v);
         v = ((tb + mterm) * 255) / den; res.blue  = COMP_W'((v > 255) ? 255 : v);
         res.hue = HUE_W'(h); res.sat = SL_W'(s); res.light = SL_W'(l);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: offers one item, holds it until the transfer, then drops valid
   // only if no further item follows right away
   // ---------------------------------------------------------------------
   task automatic send_color(rhc_op_type op, color_type given);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_in_red        <= given.red;
      req_in_green      <= given.green;
      req_in_blue       <= given.blue;
      req_in_hue        <= given.hue;
      req_in_saturation <= given.sat;
      req_in_lightness  <= given.light;
      do @(posedge clock); while (req_stall);
      expected_colors.push_back(convert_color(op, given));
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      end_burst();
      while (expected_colors.size() != 0) @(posedge clock);
   endtask

   function automatic color_type rand_color();
      color_type c;
      c.red   = COMP_W'($urandom_range(255));
      c.green = COMP_W'($urandom_range(255));
      c.blue  = COMP_W'($urandom_range(255));
      c.hue   = HUE_W'($urandom_range(HUE_FULL - 1));
      c.sat   = SL_W'($urandom_range(Q_ONE));
      c.light = SL_W'($urandom_range(Q_ONE));
      // now and then push the raw fields beyond range to exercise the
      // hue wrap and S/L saturation (and to toggle every input bit)
      if ($urandom_range(9) == 0) c.hue   = HUE_W'($urandom);
      if ($urandom_range(9) == 0) c.sat   = SL_W'($urandom);
      if ($urandom_range(9) == 0) c.light = SL_W'($urandom);
      return c;
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send_color(rhc_op_type'($urandom_range(1)), rand_color());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_rgb_corners();
      color_type c;
      logic [COMP_W-1:0] prim[8][3] = '{
         '{0,0,0}, '{255,255,255}, '{255,0,0}, '{0,255,0},
         '{0,0,255}, '{255,255,0}, '{0,255,255}, '{255,0,255}};
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c.red = prim[i][0]; c.green = prim[i][1]; c.blue = prim[i][2];
         send_color(OP_RGB2HSL, c);
      end
      // red max with blue above green: hue wraps below zero
      c.red = 8'd200; c.green = 8'd10;  c.blue = 8'd90;  send_color(OP_RGB2HSL, c);
      // ties between green and blue, for the maximum and then for the minimum
      c.red = 8'd20;  c.green = 8'd180; c.blue = 8'd180; send_color(OP_RGB2HSL, c);
      c.red = 8'd128; c.green = 8'd127; c.blue = 8'd127; send_color(OP_RGB2HSL, c);
      wait_drained();
   endtask

   task automatic test_hsl_corners();
      color_type c;
      c = '0;
      for (int k = 0; k < 6; k++) begin
         c.hue   = HUE_W'(k * HUE_SECTOR + 1000);
         c.sat   = SL_W'(Q_ONE);
         c.light = SL_W'(Q_ONE / 2);
         send_color(OP_HSL2RGB, c);
      end
      c.hue = HUE_W'(HUE_FULL - 1); c.sat = SL_W'(Q_ONE); c.light = SL_W'(Q_ONE / 2);
      send_color(OP_HSL2RGB, c);
      c.hue = '0; c.sat = '0; c.light = '0;                  send_color(OP_HSL2RGB, c);
      c.hue = '0; c.sat = SL_W'(Q_ONE); c.light = SL_W'(Q_ONE);
      send_color(OP_HSL2RGB, c);
      // out-of-range hue, saturation and lightness
      c.hue = '1; c.sat = '1; c.light = '1;                  send_color(OP_HSL2RGB, c);
      c.hue = HUE_W'(HUE_FULL); c.sat = SL_W'(Q_ONE + 1); c.light = SL_W'(3000);
      send_color(OP_HSL2RGB, c);
      // RGB fields are ignored on this path
      c.red = '1; c.green = '1; c.blue = '1;
      c.hue = HUE_W'(5000); c.sat = SL_W'(2000); c.light = SL_W'(1000);
      send_color(OP_HSL2RGB, c);
      wait_drained();
   endtask

   task automatic test_random_mixes();
      int idle[4]  = '{0, 87, 0, 29};
      int stall[4] = '{0, 0, 87, 29};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle[p];
         stall_pct     = stall[p];
         send_random(400);
         // sender pauses until everything is back
         wait_drained();
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   task automatic test_back_pressure();
      // receiver holds off while the sender keeps offering, so the pipe fills
      hold_off_cycles = 60;
      send_random(150);
      wait_drained();
      send_idle_pct = $urandom_range(60);
      stall_pct     = $urandom_range(60);
      send_random(250);
      wait_drained();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver stall: random, plus a long hold-off when requested
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall       <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: oldest expectation against each accepted result
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      color_type seen, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_out_red, rsp_out_green, rsp_out_blue,
                  rsp_out_hue, rsp_out_saturation, rsp_out_lightness};
         if (expected_colors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result r%0d g%0d b%0d h%0d s%0d l%0d",
                        seen.red, seen.green, seen.blue, seen.hue, seen.sat, seen.light);
         end else begin
            want = expected_colors.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR: mismatch exp r%0d g%0d b%0d h%0d s%0d l%0d,",
                            " got r%0d g%0d b%0d h%0d s%0d l%0d"},
                           want.red, want.green, want.blue, want.hue, want.sat,
                           want.light, seen.red, seen.green, seen.blue, seen.hue,
                           seen.sat, seen.light);
            end
         end
      end
   end

   // Watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("rgb_hsl_converter_top test failed");
            $finish;
         end
      end
   end

   initial begin
      mismatch_count    = 0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      hold_off_cycles   = 0;
      quiet_cycles      = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_RGB2HSL;
      req_in_red        = '0;
      req_in_green      = '0;
      req_in_blue       = '0;
      req_in_hue        = '0;
      req_in_saturation = '0;
      req_in_lightness  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_rgb_corners();
      test_hsl_corners();
      test_random_mixes();
      test_back_pressure();

      // let the pipe settle and catch any stray result
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_colors.size() == 0) begin
         $display("rgb_hsl_converter_top test passed");
      end else begin
         $display("rgb_hsl_converter_top test failed");
      end
      $finish;
   end

endmodule
